@@ rtl/pidff_pkg.sv @@
`timescale 1ns / 1ps
package pidff_pkg;

  // signal formats
  typedef logic signed [23:0] q16_8_t;   // signed Q16.8
  typedef logic [23:0]        gain_t;    // unsigned Q8.16
  typedef logic [22:0]        mag23_t;   // unsigned Q15.8 magnitude

  // configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_KP            = 3'd0,
    REG_KI            = 3'd1,
    REG_KD            = 3'd2,
    REG_ERROR_FF_GAIN = 3'd3,
    REG_FRICTION_FF   = 3'd4,
    REG_ERR_DEADBAND  = 3'd5,
    REG_ERR_LIMIT     = 3'd6,
    REG_OUTPUT_LIMIT  = 3'd7
  } cfg_reg_t;

  // term limits
  localparam logic signed [32:0] INTEGRAL_LIMIT = 33'sd8388607;
  localparam logic signed [32:0] P_TERM_LIMIT   = 33'sd8388607;
  localparam logic signed [33:0] D_TERM_LIMIT   = 34'sd8388607;

  // thresholds in Q16.8
  localparam q16_8_t SEP_THRESH  = 24'sd1280;  // 5.0
  localparam q16_8_t FF_THRESH   = 24'sd384;   // 1.5
  localparam q16_8_t FRIC_THRESH = 24'sd7680;  // 30.0

  localparam mag23_t LIMIT_RESET = 23'h7fffff;

endpackage

@@ rtl/pidff_in_if.sv @@
`timescale 1ns / 1ps
interface pidff_in_if;
  import pidff_pkg::*;

  logic   valid;
  logic   ready;
  q16_8_t setpoint;
  q16_8_t feedback;

  modport source (output valid, output setpoint, output feedback, input ready);
  modport sink   (input valid, input setpoint, input feedback, output ready);
endinterface

@@ rtl/pidff_out_if.sv @@
`timescale 1ns / 1ps
interface pidff_out_if;
  import pidff_pkg::*;

  logic   valid;
  logic   ready;
  q16_8_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

@@ rtl/pid_with_deadband_and_feedforward.sv @@
`timescale 1ns / 1ps
// pid controller with error deadband, integral separation and feedforward
//
// in_if  : one transaction per control sample (setpoint, feedback), Q16.8
// out_if : one transaction per sample carrying the saturated drive, Q16.8
// cfg_*  : apb-style register port, register i at byte address 4*i,
//          pready tied high, writes take effect on the access cycle
//
// pipeline: a sample accepted on in_if passes the input register, the
// error/integral stage, the multiply stage and the output register before
// its drive shows on out_if. throughput is one sample per cycle while the
// receiver does not stall, set by the integral update in the error stage.
//
// each stage holds its item until the next one frees, so while the
// receiver stalls the pipeline keeps filling its empty slots and in_if
// drops ready only once all four registers are full.
//
// reset clears the gains and feedforward to zero, both limits to full
// scale, the integral and previous error to zero, and empties the pipe.
module pid_with_deadband_and_feedforward (
  input  logic                              clk,
  input  logic                              rst_n,
  pidff_in_if.sink                          in_if,
  pidff_out_if.source                       out_if,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pidff_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pidff_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pidff_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import pidff_pkg::*;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  gain_t  kp_r, ki_r, kd_r, error_ff_gain_r;
  mag23_t friction_ff_r, err_deadband_r, err_limit_r, output_limit_r;

  cfg_reg_t cfg_sel;
  logic     cfg_wr;

  assign cfg_sel    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r            <= '0;
      ki_r            <= '0;
      kd_r            <= '0;
      error_ff_gain_r <= '0;
      friction_ff_r   <= '0;
      err_deadband_r  <= '0;
      err_limit_r     <= LIMIT_RESET;
      output_limit_r  <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_KP:            kp_r            <= cfg_pwdata[23:0];
        REG_KI:            ki_r            <= cfg_pwdata[23:0];
        REG_KD:            kd_r            <= cfg_pwdata[23:0];
        REG_ERROR_FF_GAIN: error_ff_gain_r <= cfg_pwdata[23:0];
        REG_FRICTION_FF:   friction_ff_r   <= cfg_pwdata[22:0];
        REG_ERR_DEADBAND:  err_deadband_r  <= cfg_pwdata[22:0];
        REG_ERR_LIMIT:     err_limit_r     <= cfg_pwdata[22:0];
        REG_OUTPUT_LIMIT:  output_limit_r  <= cfg_pwdata[22:0];
      endcase
    end
  end

  // readback, zero extended
  always_comb begin
    unique case (cfg_sel)
      REG_KP:            cfg_prdata = {8'd0, kp_r};
      REG_KI:            cfg_prdata = {8'd0, ki_r};
      REG_KD:            cfg_prdata = {8'd0, kd_r};
      REG_ERROR_FF_GAIN: cfg_prdata = {8'd0, error_ff_gain_r};
      REG_FRICTION_FF:   cfg_prdata = {9'd0, friction_ff_r};
      REG_ERR_DEADBAND:  cfg_prdata = {9'd0, err_deadband_r};
      REG_ERR_LIMIT:     cfg_prdata = {9'd0, err_limit_r};
      REG_OUTPUT_LIMIT:  cfg_prdata = {9'd0, output_limit_r};
    endcase
  end

  // ---------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when it drains
  // ---------------------------------------------------------------
  logic v0_r, v1_r, v2_r, ov_r;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !ov_r || out_if.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_if.ready  = rdy0;
  assign out_if.valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_if.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) ov_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------
  q16_8_t sp0_r, fb0_r;

  always_ff @(posedge clk) begin
    if (rdy0 && in_if.valid) begin
      sp0_r <= in_if.setpoint;
      fb0_r <= in_if.feedback;
    end
  end

  // ---------------------------------------------------------------
  // error stage: deadband, clamp, integral with separation
  // ---------------------------------------------------------------
  q16_8_t             prev_error_r;
  logic signed [31:0] integral_sum_r;

  logic signed [25:0] e_raw, e_db, e_cl, db26, elim26;
  q16_8_t             e_nxt;
  logic signed [32:0] sum_add, sum_sel, sum_cl;
  logic signed [31:0] sum_nxt;
  logic signed [24:0] de_nxt;
  logic               sep, ff_en_nxt, fric_pos_nxt, fric_neg_nxt;
  logic               step0;

  assign step0 = v0_r && rdy1;

  always_comb begin
    // raw error has two bits of headroom so it cannot wrap
    e_raw  = {{2{sp0_r[23]}}, sp0_r} - {{2{fb0_r[23]}}, fb0_r};
    db26   = {3'd0, err_deadband_r};
    elim26 = {3'd0, err_limit_r};

    if (e_raw <= db26 && e_raw >= -db26) e_db = '0;
    else                                 e_db = e_raw;

    if (e_db > elim26)       e_cl = elim26;
    else if (e_db < -elim26) e_cl = -elim26;
    else                     e_cl = e_db;
    e_nxt = e_cl[23:0];

    // integral is dropped while the error is large
    sep     = (e_nxt >= SEP_THRESH) || (e_nxt <= -SEP_THRESH);
    sum_add = {integral_sum_r[31], integral_sum_r} + {{9{e_nxt[23]}}, e_nxt};
    sum_sel = sep ? '0 : sum_add;
    if (sum_sel > INTEGRAL_LIMIT)       sum_cl = INTEGRAL_LIMIT;
    else if (sum_sel < -INTEGRAL_LIMIT) sum_cl = -INTEGRAL_LIMIT;
    else                                sum_cl = sum_sel;
    sum_nxt = sum_cl[31:0];

    de_nxt = {e_nxt[23], e_nxt} - {prev_error_r[23], prev_error_r};

    // feedforward gates look at the setpoint, thresholds are strict
    ff_en_nxt    = (sp0_r > FF_THRESH) || (sp0_r < -FF_THRESH);
    fric_pos_nxt = sp0_r > FRIC_THRESH;
    fric_neg_nxt = sp0_r < -FRIC_THRESH;
  end

  // controller state advances as each sample leaves the error stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r   <= '0;
      integral_sum_r <= '0;
    end else if (step0) begin
      prev_error_r   <= e_nxt;
      integral_sum_r <= sum_nxt;
    end
  end

  q16_8_t             e1_r;
  logic signed [24:0] de1_r;
  logic signed [31:0] sum1_r;
  logic               ff1_r, fp1_r, fn1_r;

  always_ff @(posedge clk) begin
    if (step0) begin
      e1_r   <= e_nxt;
      de1_r  <= de_nxt;
      sum1_r <= sum_nxt;
      ff1_r  <= ff_en_nxt;
      fp1_r  <= fric_pos_nxt;
      fn1_r  <= fric_neg_nxt;
    end
  end

  // ---------------------------------------------------------------
  // multiply stage: four parallel gain products, exact Q24.24
  // ---------------------------------------------------------------
  logic signed [24:0] kp_s, ki_s, kd_s, kf_s;
  logic signed [48:0] p_nxt, f_nxt;
  logic signed [49:0] d_nxt;
  logic signed [56:0] i_nxt;
  logic signed [24:0] fric_nxt;
  logic               step1;

  assign step1 = v1_r && rdy2;

  always_comb begin
    kp_s = $signed({1'b0, kp_r});
    ki_s = $signed({1'b0, ki_r});
    kd_s = $signed({1'b0, kd_r});
    // error feedforward only when the setpoint magnitude exceeds the threshold
    kf_s = ff1_r ? $signed({1'b0, error_ff_gain_r}) : '0;

    p_nxt = kp_s * e1_r;
    d_nxt = kd_s * de1_r;
    i_nxt = ki_s * sum1_r;
    f_nxt = kf_s * e1_r;

    if (fp1_r)      fric_nxt = $signed({2'b00, friction_ff_r});
    else if (fn1_r) fric_nxt = -$signed({2'b00, friction_ff_r});
    else            fric_nxt = '0;
  end

  logic signed [48:0] p2_r, f2_r;
  logic signed [49:0] d2_r;
  logic signed [56:0] i2_r;
  logic signed [24:0] fric2_r;

  always_ff @(posedge clk) begin
    if (step1) begin
      p2_r    <= p_nxt;
      f2_r    <= f_nxt;
      d2_r    <= d_nxt;
      i2_r    <= i_nxt;
      fric2_r <= fric_nxt;
    end
  end

  // ---------------------------------------------------------------
  // sum stage: floor shift back to Q16.8, term clamps, output clamp
  // ---------------------------------------------------------------
  logic signed [32:0] up_raw, up_cl, uf;
  logic signed [33:0] ud_raw, ud_cl;
  logic signed [40:0] ui;
  logic signed [43:0] u_sum, u_cl, olim44;
  q16_8_t             drive_nxt;
  logic               step2;

  assign step2 = v2_r && rdy3;

  always_comb begin
    // dropping the low 16 bits of a two's complement value is a floor
    up_raw = p2_r[48:16];
    ud_raw = d2_r[49:16];
    ui     = i2_r[56:16];
    uf     = f2_r[48:16];

    if (up_raw > P_TERM_LIMIT)       up_cl = P_TERM_LIMIT;
    else if (up_raw < -P_TERM_LIMIT) up_cl = -P_TERM_LIMIT;
    else                             up_cl = up_raw;

    if (ud_raw > D_TERM_LIMIT)       ud_cl = D_TERM_LIMIT;
    else if (ud_raw < -D_TERM_LIMIT) ud_cl = -D_TERM_LIMIT;
    else                             ud_cl = ud_raw;

    u_sum = {{11{up_cl[32]}}, up_cl} + {{3{ui[40]}}, ui} + {{10{ud_cl[33]}}, ud_cl}
          + {{11{uf[32]}}, uf} + {{19{fric2_r[24]}}, fric2_r};

    olim44 = {21'd0, output_limit_r};
    if (u_sum > olim44)       u_cl = olim44;
    else if (u_sum < -olim44) u_cl = -olim44;
    else                      u_cl = u_sum;
    drive_nxt = u_cl[23:0];
  end

  q16_8_t drive_r;

  always_ff @(posedge clk) begin
    if (step2) drive_r <= drive_nxt;
  end

  assign out_if.drive = drive_r;

`ifndef SYNTHESIS
  // stored integral never leaves its clamp
  a_integral_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed({integral_sum_r[31], integral_sum_r}) <= INTEGRAL_LIMIT) &&
    ($signed({integral_sum_r[31], integral_sum_r}) >= -INTEGRAL_LIMIT))
    else $error("integral state outside its limit");

  // clamped error is symmetric, so the most negative code never appears
  a_prev_error_sym: assert property (@(posedge clk) disable iff (!rst_n)
    prev_error_r != 24'sh800000)
    else $error("previous error holds the most negative code");

  // input backpressure only once every stage is occupied and output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (v0_r && v1_r && v2_r && ov_r && !out_if.ready))
    else $error("input stalled with a free pipeline slot");

  // controller state moves only when a sample leaves the error stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step0 |=> $stable(integral_sum_r) && $stable(prev_error_r))
    else $error("controller state changed without a sample");
`endif

endmodule
